// ===== design/cpi_pkg.sv =====
`timescale 1ns / 1ps

package cpi_pkg;

    // Fixed-point format
    localparam int FRAC_BITS    = 16;
    localparam int ADC_BITS_DEF = 12;
    localparam int AMP_FS       = 12;   // amps at full ADC scale
    localparam int VOLT_FS      = 60;   // volts at full ADC scale
    localparam int AMP_W        = 20;   // < 12 * 2^16
    localparam int VOLT_W       = 22;   // < 60 * 2^16

    // Datapath widths
    localparam int EXT_W   = 42;        // extended sum width ahead of saturation
    localparam int MUL_A_W = 34;        // error sum, signed
    localparam int MUL_B_W = 23;        // gain or period, zero-extended
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int GAIN_W = 22;
    localparam int PER_W  = 16;

    localparam logic [2:0] REG_VOLT_TARGET = 3'd0;
    localparam logic [2:0] REG_VOLT_KP     = 3'd1;
    localparam logic [2:0] REG_VOLT_KI     = 3'd2;
    localparam logic [2:0] REG_CURR_KP     = 3'd3;
    localparam logic [2:0] REG_CURR_KI     = 3'd4;
    localparam logic [2:0] REG_WINDUP_MODE = 3'd5;
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd6;

    localparam logic [GAIN_W-1:0] RST_VOLT_TARGET = 22'd3145728;
    localparam logic [GAIN_W-1:0] RST_VOLT_KP     = 22'd5219;
    localparam logic [GAIN_W-1:0] RST_VOLT_KI     = 22'd465;
    localparam logic [GAIN_W-1:0] RST_CURR_KP     = 22'd9658;
    localparam logic [GAIN_W-1:0] RST_CURR_KI     = 22'd876;
    localparam logic              RST_WINDUP_MODE = 1'b1;
    localparam logic [PER_W-1:0]  RST_PWM_PERIOD  = 16'd5000;

    // Loop limits, Q16.16
    localparam logic signed [31:0] VINT_MAX = 32'sd786432;
    localparam logic signed [31:0] VINT_MIN = -32'sd786432;
    localparam logic signed [31:0] IINT_MAX = 32'sd62259;
    localparam logic signed [31:0] IINT_MIN = -32'sd62259;
    localparam logic signed [31:0] VOUT_MIN = 32'sd0;
    localparam logic signed [31:0] VOUT_MAX = 32'sd786432;
    localparam logic signed [31:0] DUTY_MIN = 32'sd3277;
    localparam logic signed [31:0] DUTY_MAX = 32'sd62259;

    typedef struct packed {
        logic [GAIN_W-1:0] voltage_target;
        logic [GAIN_W-1:0] volt_prop_gain;
        logic [GAIN_W-1:0] volt_int_gain;
        logic [GAIN_W-1:0] curr_prop_gain;
        logic [GAIN_W-1:0] curr_int_gain;
        logic              windup_mode;
        logic [PER_W-1:0]  pwm_period;
    } cfg_t;

    typedef struct packed {
        logic [PER_W-1:0]  compare_value;
        logic signed [31:0] duty_fraction;
        logic signed [31:0] current_setpoint;
        logic              volt_windup;
        logic              curr_windup;
    } res_t;

    function automatic logic signed [EXT_W-1:0] sext32(input logic signed [31:0] v);
        return {{(EXT_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [EXT_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[EXT_W-1:31];
        hi_zeros = ~|v[EXT_W-1:31];
        if (hi_ones || hi_zeros) begin
            return v[31:0];
        end else if (v[EXT_W-1]) begin
            return 32'sh80000000;
        end else begin
            return 32'sh7FFFFFFF;
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

endpackage

// ===== design/cpi_regs.sv =====
`timescale 1ns / 1ps

module cpi_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpi_pkg::ADDR_W-1:0]   paddr,
    input  logic [cpi_pkg::DATA_W-1:0]   pwdata,
    output logic [cpi_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output cpi_pkg::cfg_t                cfg
);

    logic [cpi_pkg::GAIN_W-1:0] vtarget_reg, vkp_reg, vki_reg, ckp_reg, cki_reg;
    logic                       mode_reg;
    logic [cpi_pkg::PER_W-1:0]  period_reg;
    logic [2:0]                 index;
    logic                       wr_en;

    assign index  = paddr[cpi_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vtarget_reg <= cpi_pkg::RST_VOLT_TARGET;
            vkp_reg     <= cpi_pkg::RST_VOLT_KP;
            vki_reg     <= cpi_pkg::RST_VOLT_KI;
            ckp_reg     <= cpi_pkg::RST_CURR_KP;
            cki_reg     <= cpi_pkg::RST_CURR_KI;
            mode_reg    <= cpi_pkg::RST_WINDUP_MODE;
            period_reg  <= cpi_pkg::RST_PWM_PERIOD;
        end else if (wr_en) begin
            case (index)
                cpi_pkg::REG_VOLT_TARGET: vtarget_reg <= pwdata[cpi_pkg::GAIN_W-1:0];
                cpi_pkg::REG_VOLT_KP:     vkp_reg     <= pwdata[cpi_pkg::GAIN_W-1:0];
                cpi_pkg::REG_VOLT_KI:     vki_reg     <= pwdata[cpi_pkg::GAIN_W-1:0];
                cpi_pkg::REG_CURR_KP:     ckp_reg     <= pwdata[cpi_pkg::GAIN_W-1:0];
                cpi_pkg::REG_CURR_KI:     cki_reg     <= pwdata[cpi_pkg::GAIN_W-1:0];
                cpi_pkg::REG_WINDUP_MODE: mode_reg    <= pwdata[0];
                cpi_pkg::REG_PWM_PERIOD:  period_reg  <= pwdata[cpi_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (index)
            cpi_pkg::REG_VOLT_TARGET: prdata = cpi_pkg::DATA_W'(vtarget_reg);
            cpi_pkg::REG_VOLT_KP:     prdata = cpi_pkg::DATA_W'(vkp_reg);
            cpi_pkg::REG_VOLT_KI:     prdata = cpi_pkg::DATA_W'(vki_reg);
            cpi_pkg::REG_CURR_KP:     prdata = cpi_pkg::DATA_W'(ckp_reg);
            cpi_pkg::REG_CURR_KI:     prdata = cpi_pkg::DATA_W'(cki_reg);
            cpi_pkg::REG_WINDUP_MODE: prdata = cpi_pkg::DATA_W'(mode_reg);
            cpi_pkg::REG_PWM_PERIOD:  prdata = cpi_pkg::DATA_W'(period_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        cfg.voltage_target = vtarget_reg;
        cfg.volt_prop_gain = vkp_reg;
        cfg.volt_int_gain  = vki_reg;
        cfg.curr_prop_gain = ckp_reg;
        cfg.curr_int_gain  = cki_reg;
        cfg.windup_mode    = mode_reg;
        cfg.pwm_period     = period_reg;
    end

endmodule

// ===== design/cpi_mul.sv =====
`timescale 1ns / 1ps

// Shared multiplier: registered product, plus Q16.16 rescale with
// round-to-nearest (ties toward +inf) taken from the registered product.
module cpi_mul (
    input  logic                                aclk,
    input  logic signed [cpi_pkg::MUL_A_W-1:0]  mul_a,
    input  logic signed [cpi_pkg::MUL_B_W-1:0]  mul_b,
    output logic signed [cpi_pkg::PROD_W-1:0]   prod,
    output logic signed [cpi_pkg::EXT_W-1:0]    prod_rnd
);

    logic signed [cpi_pkg::PROD_W-1:0] prod_reg;
    logic signed [cpi_pkg::PROD_W:0]   prod_bias;

    always_ff @(posedge aclk) begin
        prod_reg <= cpi_pkg::PROD_W'(mul_a) * cpi_pkg::PROD_W'(mul_b);
    end

    assign prod      = prod_reg;
    assign prod_bias = {prod_reg[cpi_pkg::PROD_W-1], prod_reg}
                     + $signed((cpi_pkg::PROD_W+1)'(1 << (cpi_pkg::FRAC_BITS - 1)));
    assign prod_rnd  = prod_bias[cpi_pkg::PROD_W:cpi_pkg::FRAC_BITS];

endmodule

// ===== design/cpi_core.sv =====
`timescale 1ns / 1ps

// Sequencer for both PI loops and the compare scaling. The voltage loop
// runs first (loop_reg = 0), then the current loop reuses the same steps.
module cpi_core #(
    parameter int ADC_BITS = cpi_pkg::ADC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ADC_BITS-1:0] current_code,
    input  logic [ADC_BITS-1:0] voltage_code,
    input  cpi_pkg::cfg_t       cfg,
    input  logic                out_free,
    output logic                idle,
    output logic                done,
    output cpi_pkg::res_t       res
);

    localparam int AMP_PER_CODE  = cpi_pkg::AMP_FS  << (cpi_pkg::FRAC_BITS - ADC_BITS);
    localparam int VOLT_PER_CODE = cpi_pkg::VOLT_FS << (cpi_pkg::FRAC_BITS - ADC_BITS);
    localparam int EW = cpi_pkg::EXT_W;
    localparam int AW = cpi_pkg::MUL_A_W;
    localparam int BW = cpi_pkg::MUL_B_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ERR  = 9'b000000010,
        S_PMUL = 9'b000000100,
        S_PROP = 9'b000001000,
        S_INT  = 9'b000010000,
        S_OUT  = 9'b000100000,
        S_CMUL = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   loop_reg, loop_next;

    logic [cpi_pkg::AMP_W-1:0]  amps_reg, amps_next;
    logic [cpi_pkg::VOLT_W-1:0] volts_reg, volts_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] prop_reg, prop_next;
    logic signed [31:0] it_reg, it_next;
    logic signed [31:0] yv_reg, yv_next;
    logic signed [31:0] yi_reg, yi_next;
    logic [cpi_pkg::PER_W-1:0] cmp_reg, cmp_next;

    logic signed [31:0] err_last_reg [2];
    logic signed [31:0] err_last_next [2];
    logic signed [31:0] integ_reg [2];
    logic signed [31:0] integ_next [2];
    logic               hold_reg [2];
    logic               hold_next [2];

    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [cpi_pkg::PROD_W-1:0] prod;
    logic signed [EW-1:0]     prod_rnd;

    logic signed [EW-1:0] err_diff, int_sum, out_sum;
    logic signed [31:0]   int_sat, int_clamp, out_sat, out_clamp;
    logic signed [31:0]   ilim_lo, ilim_hi, omin, omax;
    logic                 out_of;
    logic [cpi_pkg::PROD_W-1-cpi_pkg::FRAC_BITS:0] cmp_full;

    cpi_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod     (prod),
        .prod_rnd (prod_rnd)
    );

    // loop-dependent limits
    assign ilim_lo = loop_reg ? cpi_pkg::IINT_MIN : cpi_pkg::VINT_MIN;
    assign ilim_hi = loop_reg ? cpi_pkg::IINT_MAX : cpi_pkg::VINT_MAX;
    assign omin    = loop_reg ? cpi_pkg::DUTY_MIN : cpi_pkg::VOUT_MIN;
    assign omax    = loop_reg ? cpi_pkg::DUTY_MAX : cpi_pkg::VOUT_MAX;

    // error: target - volts, or setpoint - amps
    assign err_diff = loop_reg
        ? cpi_pkg::sext32(yv_reg) - $signed(EW'(amps_reg))
        : $signed(EW'(cfg.voltage_target)) - $signed(EW'(volts_reg));

    assign int_sum   = prod_rnd + cpi_pkg::sext32(integ_reg[loop_reg]);
    assign int_sat   = cpi_pkg::sat32(int_sum);
    assign int_clamp = cpi_pkg::clamp32(int_sat, ilim_lo, ilim_hi);

    assign out_sum   = cpi_pkg::sext32(prop_reg) + cpi_pkg::sext32(it_reg);
    assign out_sat   = cpi_pkg::sat32(out_sum);
    assign out_of    = (out_sat < omin) || (out_sat > omax);
    assign out_clamp = (out_of && !cfg.windup_mode)
                     ? cpi_pkg::clamp32(out_sat, omin, omax) : out_sat;

    // duty * period >> 16; product is non-negative when duty is positive
    assign cmp_full = prod[cpi_pkg::PROD_W-1:cpi_pkg::FRAC_BITS];

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PMUL: begin
                mul_a = {{(AW-32){err_reg[31]}}, err_reg};
                mul_b = $signed(BW'(loop_reg ? cfg.curr_prop_gain : cfg.volt_prop_gain));
            end
            S_PROP: begin
                mul_a = {{(AW-32){err_reg[31]}}, err_reg}
                      + {{(AW-32){err_last_reg[loop_reg][31]}}, err_last_reg[loop_reg]};
                mul_b = $signed(BW'(loop_reg ? cfg.curr_int_gain : cfg.volt_int_gain));
            end
            S_CMUL: begin
                mul_a = {{(AW-32){yi_reg[31]}}, yi_reg};
                mul_b = $signed(BW'(cfg.pwm_period));
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        loop_next     = loop_reg;
        amps_next     = amps_reg;
        volts_next    = volts_reg;
        err_next      = err_reg;
        prop_next     = prop_reg;
        it_next       = it_reg;
        yv_next       = yv_reg;
        yi_next       = yi_reg;
        cmp_next      = cmp_reg;
        err_last_next = err_last_reg;
        integ_next    = integ_reg;
        hold_next     = hold_reg;
        done          = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    amps_next  = cpi_pkg::AMP_W'(32'(current_code) * AMP_PER_CODE);
                    volts_next = cpi_pkg::VOLT_W'(32'(voltage_code) * VOLT_PER_CODE);
                    loop_next  = 1'b0;
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next   = cpi_pkg::sat32(err_diff);
                state_next = S_PMUL;
            end
            S_PMUL: begin
                state_next = S_PROP;
            end
            S_PROP: begin
                prop_next  = cpi_pkg::sat32(prod_rnd);
                state_next = S_INT;
            end
            S_INT: begin
                integ_next[loop_reg]    = int_clamp;
                err_last_next[loop_reg] = err_reg;
                // previous step's flag zeroes the integral term
                it_next    = hold_reg[loop_reg] ? 32'sd0 : int_clamp;
                state_next = S_OUT;
            end
            S_OUT: begin
                hold_next[loop_reg] = out_of && cfg.windup_mode;
                if (loop_reg) begin
                    yi_next    = out_clamp;
                    state_next = S_CMUL;
                end else begin
                    yv_next    = out_clamp;
                    loop_next  = 1'b1;
                    state_next = S_ERR;
                end
            end
            S_CMUL: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (yi_reg <= 32'sd0) begin
                    cmp_next = '0;
                end else if (cmp_full > (cpi_pkg::PROD_W-cpi_pkg::FRAC_BITS)'(cfg.pwm_period)) begin
                    cmp_next = cfg.pwm_period;
                end else begin
                    cmp_next = cmp_full[cpi_pkg::PER_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            loop_reg        <= 1'b0;
            err_last_reg[0] <= '0;
            err_last_reg[1] <= '0;
            integ_reg[0]    <= '0;
            integ_reg[1]    <= '0;
            hold_reg[0]     <= 1'b0;
            hold_reg[1]     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            loop_reg        <= loop_next;
            err_last_reg    <= err_last_next;
            integ_reg       <= integ_next;
            hold_reg        <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        amps_reg  <= amps_next;
        volts_reg <= volts_next;
        err_reg   <= err_next;
        prop_reg  <= prop_next;
        it_reg    <= it_next;
        yv_reg    <= yv_next;
        yi_reg    <= yi_next;
        cmp_reg   <= cmp_next;
    end

    assign idle = (state_reg == S_IDLE);

    always_comb begin
        res.compare_value    = cmp_reg;
        res.duty_fraction    = yi_reg;
        res.current_setpoint = yv_reg;
        res.volt_windup      = hold_reg[0];
        res.curr_windup      = hold_reg[1];
    end

endmodule

// ===== design/cascaded_pi_converter_control.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// -------   ---  ---------          -------
// s_        in   s_valid/s_ready    current_code, voltage_code (ADC codes)
// m_        out  m_valid/m_ready    compare, duty, setpoint, two windup flags
// APB       in   psel/penable       7 config registers at 4*i, pready tied high
//
// Each item goes from accept to the result in the output register through
// five steps per PI loop on the one shared multiplier, two for the compare
// scaling and one to hand off; s_ready returns as the result is registered.
// Reset (aresetn low, synchronous) restores register defaults and clears
// loop state and hold flags. A waiting result does not block the next accept;
// the sequencer stalls at its last step until the previous result is taken.

module cascaded_pi_converter_control #(
    parameter int ADC_BITS = cpi_pkg::ADC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpi_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpi_pkg::DATA_W-1:0]  pwdata,
    output logic [cpi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ADC_BITS-1:0]         s_current_code,
    input  logic [ADC_BITS-1:0]         s_voltage_code,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cpi_pkg::PER_W-1:0]   m_compare_value,
    output logic signed [31:0]          m_duty_fraction,
    output logic signed [31:0]          m_current_setpoint,
    output logic                        m_volt_windup,
    output logic                        m_curr_windup
);

    cpi_pkg::cfg_t cfg;
    cpi_pkg::res_t res;
    cpi_pkg::res_t out_reg;
    logic          m_valid_reg;
    logic          core_idle;
    logic          core_done;
    logic          out_free;
    logic          start;

    cpi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // output slot frees when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = core_idle;
    assign start    = s_valid && core_idle;

    cpi_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .current_code (s_current_code),
        .voltage_code (s_voltage_code),
        .cfg          (cfg),
        .out_free     (out_free),
        .idle         (core_idle),
        .done         (core_done),
        .res          (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_done) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_compare_value    = out_reg.compare_value;
    assign m_duty_fraction    = out_reg.duty_fraction;
    assign m_current_setpoint = out_reg.current_setpoint;
    assign m_volt_windup      = out_reg.volt_windup;
    assign m_curr_windup      = out_reg.curr_windup;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for cascaded_pi_converter_control.
// Items are ADC sample pairs sent on the s_ channel. A predictor in this file
// tracks both PI loops and the register shadow, computes each expected result
// when the item is accepted, and queues it. A checker process compares every
// accepted result against the head of that queue, field by field.
// Directed tests cover field extremes, duty above one, negative duty, a zero
// period, both windup modes and register write masking. Random traffic then
// runs under several idle patterns, plus one long receiver hold-off.

module tb_top;

    import cpi_pkg::*;

    localparam int CODE_W        = ADC_BITS_DEF;
    localparam int CODE_MAX      = (1 << CODE_W) - 1;
    localparam int BLOCK_LATENCY = 14;     // covers accept to result
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS   = 10;

    // ADC scaling in Q16.16: 12 A and 60 V over 4096 codes
    localparam longint AMPS_PER_LSB  = 192;
    localparam longint VOLTS_PER_LSB = 960;

    // loop limits, Q16.16
    localparam longint VOLT_INT_LIMIT = 786432;    // 12 V
    localparam longint CURR_INT_LIMIT = 62259;     // 0.95
    localparam longint VOLT_OUT_MIN   = 0;
    localparam longint VOLT_OUT_MAX   = 786432;
    localparam longint DUTY_LOW       = 3277;      // 0.05
    localparam longint DUTY_HIGH      = 62259;     // 0.95
    localparam longint S32_MAX        = 64'sd2147483647;
    localparam longint S32_MIN        = -64'sd2147483648;

    // no register decodes at this index
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef enum int {
        CFG_TYPICAL,
        CFG_WIDE,
        CFG_ALL_MIN,
        CFG_ALL_MAX
    } cfg_flavor_t;

    typedef struct {
        logic signed [31:0] err_last;
        logic signed [31:0] integ;
        logic               hold;
    } loop_state_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CODE_W-1:0] s_current_code = '0;
    logic [CODE_W-1:0] s_voltage_code = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PER_W-1:0]   m_compare_value;
    logic signed [31:0] m_duty_fraction;
    logic signed [31:0] m_current_setpoint;
    logic               m_volt_windup;
    logic               m_curr_windup;

    cascaded_pi_converter_control dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_current_code     (s_current_code),
        .s_voltage_code     (s_voltage_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_compare_value    (m_compare_value),
        .m_duty_fraction    (m_duty_fraction),
        .m_current_setpoint (m_current_setpoint),
        .m_volt_windup      (m_volt_windup),
        .m_curr_windup      (m_curr_windup)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    cfg_t        ctrl_cfg;          // shadow of the register file
    loop_state_t volt_loop;
    loop_state_t curr_loop;
    res_t        pending_results[$];

    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  walk_current = 1024;
    logic rx_hold = 1'b0;
    event rx_hold_start;

    function automatic longint sat_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q16.16 product, round half up. Arithmetic shift floors negatives.
    function automatic longint gain_mul(input longint a, input longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    task automatic reset_predictor();
        ctrl_cfg.voltage_target = RST_VOLT_TARGET;
        ctrl_cfg.volt_prop_gain = RST_VOLT_KP;
        ctrl_cfg.volt_int_gain  = RST_VOLT_KI;
        ctrl_cfg.curr_prop_gain = RST_CURR_KP;
        ctrl_cfg.curr_int_gain  = RST_CURR_KI;
        ctrl_cfg.windup_mode    = RST_WINDUP_MODE;
        ctrl_cfg.pwm_period     = RST_PWM_PERIOD;
        volt_loop = '{err_last: '0, integ: '0, hold: 1'b0};
        curr_loop = '{err_last: '0, integ: '0, hold: 1'b0};
    endtask

    // One PI loop with trapezoidal integrator. The integral term is dropped
    // while last step's hold flag is set; the integrator itself still runs.
    task automatic pi_update(input longint err, input longint kp, input longint ki,
                             input longint ilim, input longint omin, input longint omax,
                             inout loop_state_t st, output logic signed [31:0] y);
        longint prop;
        longint integ;
        longint sum;
        logic   out_of_range;
        prop  = sat_s32(gain_mul(err, kp));
        integ = sat_s32(gain_mul(err + longint'(st.err_last), ki) + longint'(st.integ));
        integ = clip(integ, -ilim, ilim);
        st.integ    = integ[31:0];
        st.err_last = err[31:0];
        if (st.hold) integ = 0;
        sum = sat_s32(prop + integ);
        out_of_range = (sum < omin) || (sum > omax);
        if (out_of_range && !ctrl_cfg.windup_mode) sum = clip(sum, omin, omax);
        st.hold = out_of_range && ctrl_cfg.windup_mode;
        y = sum[31:0];
    endtask

    task automatic predict_converter_step(input logic [CODE_W-1:0] cur,
                                          input logic [CODE_W-1:0] volt,
                                          output res_t r);
        longint amps;
        longint volts;
        longint verr;
        longint ierr;
        longint cmp;
        logic signed [31:0] yv;
        logic signed [31:0] yi;
        amps  = longint'(cur) * AMPS_PER_LSB;
        volts = longint'(volt) * VOLTS_PER_LSB;
        verr  = sat_s32(longint'(ctrl_cfg.voltage_target) - volts);
        pi_update(verr, ctrl_cfg.volt_prop_gain, ctrl_cfg.volt_int_gain, VOLT_INT_LIMIT,
                  VOLT_OUT_MIN, VOLT_OUT_MAX, volt_loop, yv);
        ierr = sat_s32(longint'(yv) - amps);
        pi_update(ierr, ctrl_cfg.curr_prop_gain, ctrl_cfg.curr_int_gain, CURR_INT_LIMIT,
                  DUTY_LOW, DUTY_HIGH, curr_loop, yi);
        // compare = duty * period, floored, held to 0..period
        if (yi <= 0) begin
            cmp = 0;
        end else begin
            cmp = (longint'(yi) * longint'(ctrl_cfg.pwm_period)) >>> 16;
            if (cmp > longint'(ctrl_cfg.pwm_period)) cmp = ctrl_cfg.pwm_period;
        end
        r.compare_value    = cmp[15:0];
        r.duty_fraction    = yi;
        r.current_setpoint = yv;
        r.volt_windup      = volt_loop.hold;
        r.curr_windup      = curr_loop.hold;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compares on each m_ handshake
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, field, want, got);
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no item outstanding: compare %0d duty %0d",
                             $realtime, m_compare_value, m_duty_fraction);
            end else begin
                want = pending_results.pop_front();
                if (m_compare_value !== want.compare_value)
                    note_mismatch("compare_value", want.compare_value, m_compare_value);
                if (m_duty_fraction !== want.duty_fraction)
                    note_mismatch("duty_fraction", want.duty_fraction, m_duty_fraction);
                if (m_current_setpoint !== want.current_setpoint)
                    note_mismatch("current_setpoint", want.current_setpoint,
                                  m_current_setpoint);
                if (m_volt_windup !== want.volt_windup)
                    note_mismatch("volt_windup", want.volt_windup, m_volt_windup);
                if (m_curr_windup !== want.curr_windup)
                    note_mismatch("curr_windup", want.curr_windup, m_curr_windup);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready = !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // hold-off counted here so the sender keeps pushing while the output backs up
    always @(rx_hold_start) begin
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic apply_reset();
        reset_predictor();
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    endtask

    // APB write: setup then access; register lands when pready is seen
    task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_VOLT_TARGET: ctrl_cfg.voltage_target = value[GAIN_W-1:0];
            REG_VOLT_KP:     ctrl_cfg.volt_prop_gain = value[GAIN_W-1:0];
            REG_VOLT_KI:     ctrl_cfg.volt_int_gain  = value[GAIN_W-1:0];
            REG_CURR_KP:     ctrl_cfg.curr_prop_gain = value[GAIN_W-1:0];
            REG_CURR_KI:     ctrl_cfg.curr_int_gain  = value[GAIN_W-1:0];
            REG_WINDUP_MODE: ctrl_cfg.windup_mode    = value[0];
            REG_PWM_PERIOD:  ctrl_cfg.pwm_period     = value[PER_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one item, optionally after an idle gap; predict on acceptance.
    task automatic send_sample(input logic [CODE_W-1:0] cur, input logic [CODE_W-1:0] volt);
        int   gap;
        logic taken;
        res_t r;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid        = 1'b0;
            s_current_code = $urandom;   // junk while idle
            s_voltage_code = $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_current_code = cur;
        s_voltage_code = volt;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        predict_converter_step(cur, volt, r);
        pending_results.push_back(r);
    endtask

    // Stop offering, let every result drain, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (BLOCK_LATENCY + 8) @(posedge aclk);
    endtask

    task automatic load_config(input cfg_flavor_t flavor);
        case (flavor)
            CFG_TYPICAL: begin
                write_register(REG_VOLT_TARGET, $urandom_range(3932160));
                write_register(REG_VOLT_KP, $urandom_range(20000));
                write_register(REG_VOLT_KI, $urandom_range(2000));
                write_register(REG_CURR_KP, $urandom_range(40000));
                write_register(REG_CURR_KI, $urandom_range(4000));
                write_register(REG_WINDUP_MODE, $urandom_range(1));
                write_register(REG_PWM_PERIOD, $urandom_range(65535, 1));
            end
            CFG_WIDE: begin
                // full 32-bit values, upper bits must be dropped
                write_register(REG_VOLT_TARGET, $urandom);
                write_register(REG_VOLT_KP, $urandom);
                write_register(REG_VOLT_KI, $urandom);
                write_register(REG_CURR_KP, $urandom);
                write_register(REG_CURR_KI, $urandom);
                write_register(REG_WINDUP_MODE, $urandom);
                write_register(REG_PWM_PERIOD, $urandom_range(65535, 1));
            end
            CFG_ALL_MIN: begin
                write_register(REG_VOLT_TARGET, 0);
                write_register(REG_VOLT_KP, 0);
                write_register(REG_VOLT_KI, 0);
                write_register(REG_CURR_KP, 0);
                write_register(REG_CURR_KI, 0);
                write_register(REG_WINDUP_MODE, 0);
                write_register(REG_PWM_PERIOD, 1);
            end
            default: begin
                write_register(REG_VOLT_TARGET, 3932160);
                write_register(REG_VOLT_KP, 4194303);
                write_register(REG_VOLT_KI, 4194303);
                write_register(REG_CURR_KP, 4194303);
                write_register(REG_CURR_KI, 4194303);
                write_register(REG_WINDUP_MODE, 1);
                write_register(REG_PWM_PERIOD, 65535);
            end
        endcase
    endtask

    // Mostly a slow walk around the operating point so the integrators and
    // hold flags get exercised; some full-range and corner samples mixed in.
    task automatic send_random_sample();
        int cur;
        int volt;
        int target_code;
        target_code = int'(ctrl_cfg.voltage_target) / int'(VOLTS_PER_LSB);
        case ($urandom_range(9))
            0, 1: begin
                cur  = $urandom_range(CODE_MAX);
                volt = $urandom_range(CODE_MAX);
            end
            2: begin
                cur  = $urandom_range(1) ? CODE_MAX : 0;
                volt = $urandom_range(1) ? CODE_MAX : 0;
            end
            default: begin
                cur  = walk_current + int'($urandom_range(64)) - 32;
                volt = target_code + int'($urandom_range(40)) - 20;
            end
        endcase
        cur  = int'(clip(cur, 0, CODE_MAX));
        volt = int'(clip(volt, 0, CODE_MAX));
        walk_current = cur;
        send_sample(cur[CODE_W-1:0], volt[CODE_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset register values, field extremes
    task automatic test_reset_values();
        send_sample(0, 0);
        send_sample(CODE_MAX, CODE_MAX);
        send_sample(0, CODE_MAX);
        send_sample(CODE_MAX, 0);
        send_sample(12'h800, 12'd3276);
    endtask

    // duty above one, negative duty, zero period, clamping mode
    task automatic test_output_limits();
        wait_idle();
        write_register(REG_WINDUP_MODE, 1);
        write_register(REG_VOLT_KP, 4194303);
        write_register(REG_CURR_KP, 4194303);
        write_register(REG_PWM_PERIOD, 65535);
        send_sample(0, 0);                    // large positive error, duty far above one
        send_sample(0, 0);
        send_sample(CODE_MAX, CODE_MAX);      // overvoltage, duty driven negative
        send_sample(CODE_MAX, CODE_MAX);
        wait_idle();
        write_register(REG_PWM_PERIOD, 0);
        send_sample(0, 0);
        send_sample(CODE_MAX, CODE_MAX);
        wait_idle();
        write_register(REG_WINDUP_MODE, 0);   // outputs clamp instead of flagging
        write_register(REG_PWM_PERIOD, 5000);
        send_sample(0, 0);
        send_sample(CODE_MAX, CODE_MAX);
    endtask

    // over-wide values keep only their low bits, unmapped index is ignored
    task automatic test_register_masks();
        wait_idle();
        write_register(REG_VOLT_TARGET, 32'hFFFF_FFFF);
        write_register(REG_VOLT_KP, 32'hFFFF_FFFF);
        write_register(REG_VOLT_KI, 32'hFFFF_FFFF);
        write_register(REG_CURR_KP, 32'hFFFF_FFFF);
        write_register(REG_CURR_KI, 32'hFFFF_FFFF);
        write_register(REG_WINDUP_MODE, 32'hFFFF_FFFE);
        write_register(REG_PWM_PERIOD, 32'hFFFF_FFFF);
        write_register(REG_UNUSED, 32'h0000_0000);
        send_sample(12'h555, 12'hAAA);
        send_sample(12'hAAA, 12'h555);
        wait_idle();
        load_config(CFG_ALL_MIN);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(12'h123, 12'hFED);
        send_sample(CODE_MAX, 0);
    endtask

    // receiver stalls for a long time while items keep coming
    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_config(CFG_TYPICAL);
        -> rx_hold_start;
        repeat (40) send_random_sample();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++) begin
            wait_idle();
            case (seg)
                0: load_config(CFG_TYPICAL);
                1: load_config(CFG_WIDE);
                2: load_config($urandom_range(1) ? CFG_ALL_MAX : CFG_ALL_MIN);
                default: load_config(CFG_TYPICAL);
            endcase
            repeat (items / 4) send_random_sample();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        apply_reset();
        test_reset_values();
        test_output_limits();
        test_register_masks();
        test_output_backpressure();
        test_random_traffic(15, 73, 264);
        test_random_traffic(73, 15, 264);
        test_random_traffic(0, 0, 264);
        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("cascaded_pi_converter_control test passed");
        end else begin
            $display("cascaded_pi_converter_control test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("cascaded_pi_converter_control test failed");
        $finish;
    end

endmodule
